/* hw/rtl/mrd_pkg.sv */
// mrd_pkg: shared constants, codes and payload types of the MMIO region decoder.
// No dependencies; every other file in hw/rtl refers to it by scoped names.
`timescale 1ns / 1ps

package mrd_pkg;

    // Sizing of the window table and the backing store.
    // POOL_BYTES and PAGE_BYTES are powers of two.
    localparam int NUM_WINDOWS = 16;
    localparam int POOL_BYTES  = 65536;
    localparam int PAGE_BYTES  = 4096;

    localparam int WIN_IW  = $clog2(NUM_WINDOWS);
    localparam int COUNT_W = $clog2(NUM_WINDOWS + 1);
    localparam int POOL_AW = $clog2(POOL_BYTES);
    localparam int PN_W    = $clog2(POOL_BYTES + 1);

    // Store rows: eight byte lanes per row
    localparam int LANES      = 8;
    localparam int LANE_IW    = $clog2(LANES);
    localparam int ROW_AW     = POOL_AW - LANE_IW;
    localparam int STORE_ROWS = POOL_BYTES / LANES;

    // Field widths
    localparam int OP_W     = 2;
    localparam int ADDR_W   = 32;
    localparam int SIZE_W   = 17;
    localparam int LEN_W    = 4;
    localparam int DATA_W   = 64;
    localparam int STATUS_W = 2;
    localparam int REGION_W = 4;
    localparam int OFFSET_W = 16;
    localparam int CFG_W    = 32;
    localparam int CFG_IW   = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd2;
    localparam logic [OP_W-1:0] OP_RSVD  = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNMAPPED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CONFLICT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    // Configuration register indexes and reset values
    localparam logic [CFG_IW-1:0] CFG_MEM_BASE = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_MEM_SIZE = 2'd1;
    localparam logic [CFG_W-1:0]  MEM_BASE_RST = 32'h8000_0000;
    localparam logic [CFG_W-1:0]  MEM_SIZE_RST = 32'h0800_0000;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] wdata;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [REGION_W-1:0] region;
        logic [OFFSET_W-1:0] offset;
        logic [DATA_W-1:0]   rdata;
    } t_out_item;

    typedef logic [LANES-1:0][7:0] t_row;

    // Outcome of the add checks
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [REGION_W-1:0] region;
        logic [OFFSET_W-1:0] offset;
    } t_add_res;

    // Address lookup outcome
    typedef struct packed {
        logic              mapped;
        logic [WIN_IW-1:0] idx;
    } t_hit;

    // Fields of the selected window
    typedef struct packed {
        logic [ADDR_W-1:0]  low;
        logic [POOL_AW-1:0] base;
    } t_sel;

endpackage

/* hw/rtl/mrd_store.sv */
// mrd_store: backing byte store, rows of eight byte lanes, one synchronous port.
// Clears itself row by row after reset. Depends on mrd_pkg.
`timescale 1ns / 1ps

module mrd_store (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [mrd_pkg::ROW_AW-1:0]        i_row,
    input  logic                              i_rd_en,
    input  logic [mrd_pkg::LANES-1:0]         i_wr_be,
    input  mrd_pkg::t_row                     i_wr_data,
    output mrd_pkg::t_row                     o_rd_data,
    output logic                              o_busy
);

    mrd_pkg::t_row                 r_mem [mrd_pkg::STORE_ROWS];
    mrd_pkg::t_row                 r_rd_data;
    logic                          r_busy;
    logic [mrd_pkg::ROW_AW-1:0]    r_clr_row;

    // Clearing sweep, one row per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_row <= '0;
        end else if (r_busy) begin
            r_clr_row <= r_clr_row + mrd_pkg::ROW_AW'(1);
            if (r_clr_row == mrd_pkg::ROW_AW'(mrd_pkg::STORE_ROWS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Lane-masked write, zero rows during the sweep
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_row] <= '0;
        end else begin
            for (int l = 0; l < mrd_pkg::LANES; l++) begin
                if (i_wr_be[l]) begin
                    r_mem[i_row][l] <= i_wr_data[l];
                end
            end
        end
    end

    // Registered read; data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_row];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

/* hw/rtl/mrd_window_table.sv */
// mrd_window_table: window bounds and slice bases, fill count, pool pointer,
// add checks and address lookup. Depends on mrd_pkg.
`timescale 1ns / 1ps

module mrd_window_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [mrd_pkg::ADDR_W-1:0]        i_addr,
    input  logic [mrd_pkg::ADDR_W:0]          i_hi,
    input  logic [mrd_pkg::SIZE_W-1:0]        i_size,
    input  logic [mrd_pkg::CFG_W-1:0]         i_mem_base,
    input  logic [mrd_pkg::CFG_W-1:0]         i_mem_size,
    input  logic                              i_commit,
    input  logic [mrd_pkg::WIN_IW-1:0]        i_sel_idx,
    output mrd_pkg::t_add_res                 o_add,
    output mrd_pkg::t_hit                     o_hit,
    output mrd_pkg::t_sel                     o_sel
);

    localparam int SUM_W =
        ((mrd_pkg::PN_W > mrd_pkg::SIZE_W) ? mrd_pkg::PN_W : mrd_pkg::SIZE_W) + 2;

    logic [mrd_pkg::ADDR_W-1:0]  r_low  [mrd_pkg::NUM_WINDOWS];
    logic [mrd_pkg::ADDR_W-1:0]  r_high [mrd_pkg::NUM_WINDOWS];
    logic [mrd_pkg::POOL_AW-1:0] r_base [mrd_pkg::NUM_WINDOWS];
    logic [mrd_pkg::COUNT_W-1:0] r_count;
    logic [mrd_pkg::PN_W-1:0]    r_pool_next;

    logic [mrd_pkg::NUM_WINDOWS-1:0] live;
    logic [mrd_pkg::NUM_WINDOWS-1:0] hit;
    logic [mrd_pkg::NUM_WINDOWS-1:0] meet;
    logic [mrd_pkg::ADDR_W:0]        mem_hi;
    logic                            bad;
    logic                            full;
    logic                            pool_full;
    logic [SUM_W-1:0]                sum;
    logic [SUM_W-1:0]                rnd;
    logic [SUM_W-1:0]                nx;
    logic [mrd_pkg::WIN_IW-1:0]      hit_idx;

    // Per-entry compares against the live entries
    always_comb begin
        for (int i = 0; i < mrd_pkg::NUM_WINDOWS; i++) begin
            live[i] = mrd_pkg::COUNT_W'(i) < r_count;
            hit[i]  = live[i] && (i_addr >= r_low[i]) && (i_addr <= r_high[i]);
            meet[i] = live[i] && ({1'b0, i_addr} <= {1'b0, r_high[i]})
                      && ({1'b0, r_low[i]} <= i_hi);
        end
    end

    // Windows never overlap, so at most one entry hits
    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < mrd_pkg::NUM_WINDOWS; i++) begin
            if (hit[i]) begin
                hit_idx = mrd_pkg::WIN_IW'(i);
            end
        end
    end

    assign o_hit.mapped = |hit;
    assign o_hit.idx    = hit_idx;

    // Add checks: empty or wrapping window, main memory touch, table, overlap, pool
    assign mem_hi = {1'b0, i_mem_base} + {1'b0, i_mem_size} - (mrd_pkg::ADDR_W + 1)'(1);
    assign bad    = (i_size == '0) || i_hi[mrd_pkg::ADDR_W]
                    || ((i_mem_size != '0) && ({1'b0, i_addr} <= mem_hi)
                        && ({1'b0, i_mem_base} <= i_hi));
    assign full   = r_count >= mrd_pkg::COUNT_W'(mrd_pkg::NUM_WINDOWS);

    // Pool pointer moves past the slice, rounded up to a page and saturated
    assign sum       = SUM_W'(r_pool_next) + SUM_W'(i_size);
    assign pool_full = sum > SUM_W'(mrd_pkg::POOL_BYTES);
    assign rnd       = (sum + SUM_W'(mrd_pkg::PAGE_BYTES - 1))
                       & ~SUM_W'(mrd_pkg::PAGE_BYTES - 1);
    assign nx        = (rnd > SUM_W'(mrd_pkg::POOL_BYTES)) ?
                       SUM_W'(mrd_pkg::POOL_BYTES) : rnd;

    always_comb begin
        if (bad) begin
            o_add.status = mrd_pkg::ST_CONFLICT;
        end else if (full) begin
            o_add.status = mrd_pkg::ST_FULL;
        end else if (|meet) begin
            o_add.status = mrd_pkg::ST_CONFLICT;
        end else if (pool_full) begin
            o_add.status = mrd_pkg::ST_FULL;
        end else begin
            o_add.status = mrd_pkg::ST_OK;
        end
        o_add.region = mrd_pkg::REGION_W'(r_count[mrd_pkg::WIN_IW-1:0]);
        o_add.offset = mrd_pkg::OFFSET_W'(r_pool_next);
    end

    // Selected entry for offset forming
    assign o_sel.low  = r_low[i_sel_idx];
    assign o_sel.base = r_base[i_sel_idx];

    // Count and pool pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pool_next <= '0;
        end else if (i_commit) begin
            r_count     <= r_count + mrd_pkg::COUNT_W'(1);
            r_pool_next <= mrd_pkg::PN_W'(nx);
        end
    end

    // Entry write at the fill position
    always_ff @(posedge i_clk) begin
        if (i_commit) begin
            r_low[r_count[mrd_pkg::WIN_IW-1:0]]  <= i_addr;
            r_high[r_count[mrd_pkg::WIN_IW-1:0]] <= i_hi[mrd_pkg::ADDR_W-1:0];
            r_base[r_count[mrd_pkg::WIN_IW-1:0]] <= mrd_pkg::POOL_AW'(r_pool_next);
        end
    end

endmodule

/* hw/rtl/mmio_region_decoder.sv */
// mmio_region_decoder: top level; item sequencer, configuration registers and
// output register. Depends on mrd_pkg, mrd_window_table and mrd_store.
`timescale 1ns / 1ps
//
// Use:
//   Items enter on the i_in_* valid/ready channel, one at a time. Each item with
//   op add, read or write yields one result on the o_out_* channel; op 3 is
//   taken and dropped in the idle state. mem_base and mem_size are to be written
//   through the i_cfg_* port while the block is idle; the block does not enforce it.
// Sequence:
//   Add items and accesses to unmapped addresses pass through lookup, then result,
//   before the next input transfer. Mapped reads and writes pass through lookup,
//   offset forming, then two beats on the single port of the backing store, since
//   an unaligned access spans two eight-byte rows, then result. A result becomes
//   valid in the output register as its result step ends.
// Reset:
//   After reset the backing store is cleared one row a cycle, all 8192 rows;
//   o_in_ready rises in the cycle after the sweep ends. Configuration writes are
//   taken during the sweep.
// Stall:
//   A result waits in the output register. The next item is accepted and worked
//   on meanwhile; it is held in its result step until the register frees.
//

module mmio_region_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  mrd_pkg::t_in_item               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output mrd_pkg::t_out_item              o_out_data,
    input  logic                            i_cfg_we,
    input  logic [mrd_pkg::CFG_IW-1:0]      i_cfg_idx,
    input  logic [mrd_pkg::CFG_W-1:0]       i_cfg_wdata
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_EVAL  = 7'b0000100,
        S_ADDR  = 7'b0001000,
        S_BEAT0 = 7'b0010000,
        S_BEAT1 = 7'b0100000,
        S_FIN   = 7'b1000000
    } t_state;

    t_state                               r_state;
    t_state                               n_state;

    logic [mrd_pkg::CFG_W-1:0]            r_mem_base;
    logic [mrd_pkg::CFG_W-1:0]            r_mem_size;

    logic [mrd_pkg::OP_W-1:0]             r_op;
    logic [mrd_pkg::ADDR_W-1:0]           r_addr;
    logic [mrd_pkg::ADDR_W:0]             r_hi;
    logic [mrd_pkg::SIZE_W-1:0]           r_size;
    logic [mrd_pkg::LEN_W-1:0]            r_len;
    logic [mrd_pkg::DATA_W-1:0]           r_wdata;
    logic [mrd_pkg::WIN_IW-1:0]           r_idx;
    logic [mrd_pkg::STATUS_W-1:0]         r_status;
    logic [mrd_pkg::REGION_W-1:0]         r_region;
    logic [mrd_pkg::OFFSET_W-1:0]         r_offset;
    logic [mrd_pkg::POOL_AW-1:0]          r_start;
    mrd_pkg::t_row                        r_row0;
    logic                                 r_out_valid;
    mrd_pkg::t_out_item                   r_out_data;

    logic                                 in_xfer;
    logic                                 out_free;
    logic                                 tbl_commit;
    mrd_pkg::t_add_res                    tbl_add;
    mrd_pkg::t_hit                        tbl_hit;
    mrd_pkg::t_sel                        tbl_sel;
    logic [mrd_pkg::OFFSET_W-1:0]         off;
    logic [mrd_pkg::POOL_AW-1:0]          start;

    logic [mrd_pkg::LANE_IW-1:0]          s0;
    logic [mrd_pkg::ROW_AW-1:0]           row0;
    logic [mrd_pkg::ROW_AW-1:0]           st_row;
    logic                                 st_rd_en;
    logic [mrd_pkg::LANES-1:0]            st_be;
    mrd_pkg::t_row                        st_wdata;
    mrd_pkg::t_row                        st_rdata;
    logic                                 st_busy;
    mrd_pkg::t_row                        wd_row;
    logic [mrd_pkg::LANES-1:0]            lane_act;
    logic [mrd_pkg::LANES-1:0]            lane_row0;
    mrd_pkg::t_row                        rd_bytes;
    logic [mrd_pkg::DATA_W-1:0]           res_rdata;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign tbl_commit = (r_state == S_EVAL) && (r_op == mrd_pkg::OP_ADD)
                        && (tbl_add.status == mrd_pkg::ST_OK);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_base <= mrd_pkg::MEM_BASE_RST;
            r_mem_size <= mrd_pkg::MEM_SIZE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mrd_pkg::CFG_MEM_BASE: r_mem_base <= i_cfg_wdata;
                mrd_pkg::CFG_MEM_SIZE: r_mem_size <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    mrd_window_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_addr     (r_addr),
        .i_hi       (r_hi),
        .i_size     (r_size),
        .i_mem_base (r_mem_base),
        .i_mem_size (r_mem_size),
        .i_commit   (tbl_commit),
        .i_sel_idx  (r_idx),
        .o_add      (tbl_add),
        .o_hit      (tbl_hit),
        .o_sel      (tbl_sel)
    );

    // Offset in the window and start byte in the store, wrapping at its end
    assign off   = r_addr[mrd_pkg::OFFSET_W-1:0] - tbl_sel.low[mrd_pkg::OFFSET_W-1:0];
    assign start = tbl_sel.base + mrd_pkg::POOL_AW'(off);

    // Lane mapping: byte k of the access sits in lane (s0 + k), row0 or the next row
    assign s0   = r_start[mrd_pkg::LANE_IW-1:0];
    assign row0 = r_start[mrd_pkg::POOL_AW-1:mrd_pkg::LANE_IW];

    always_comb begin
        logic [mrd_pkg::LANE_IW-1:0] k;
        for (int l = 0; l < mrd_pkg::LANES; l++) begin
            k            = mrd_pkg::LANE_IW'(l) - s0;
            lane_act[l]  = mrd_pkg::LEN_W'(k) < r_len;
            lane_row0[l] = mrd_pkg::LANE_IW'(l) >= s0;
            wd_row[l]    = r_wdata[8*k +: 8];
        end
    end

    // Store port: row0 in the first beat, the following row in the second
    always_comb begin
        st_row   = (r_state == S_BEAT1) ? row0 + mrd_pkg::ROW_AW'(1) : row0;
        st_rd_en = ((r_state == S_BEAT0) || (r_state == S_BEAT1))
                   && (r_op == mrd_pkg::OP_READ);
        st_wdata = wd_row;
        st_be    = '0;
        if (r_op == mrd_pkg::OP_WRITE) begin
            if (r_state == S_BEAT0) begin
                st_be = lane_act & lane_row0;
            end else if (r_state == S_BEAT1) begin
                st_be = lane_act & ~lane_row0;
            end
        end
    end

    mrd_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_row     (st_row),
        .i_rd_en   (st_rd_en),
        .i_wr_be   (st_be),
        .i_wr_data (st_wdata),
        .o_rd_data (st_rdata),
        .o_busy    (st_busy)
    );

    // Read assembly: lanes from row0 and the second row, rotated back to byte 0
    always_comb begin
        logic [mrd_pkg::LANE_IW-1:0] lane;
        for (int k = 0; k < mrd_pkg::LANES; k++) begin
            lane = mrd_pkg::LANE_IW'(k) + s0;
            if (mrd_pkg::LEN_W'(k) >= r_len) begin
                rd_bytes[k] = '0;
            end else if (lane >= s0) begin
                rd_bytes[k] = r_row0[lane];
            end else begin
                rd_bytes[k] = st_rdata[lane];
            end
        end
    end

    always_comb begin
        if (r_status == mrd_pkg::ST_UNMAPPED) begin
            res_rdata = '1;
        end else if ((r_status == mrd_pkg::ST_OK) && (r_op == mrd_pkg::OP_READ)) begin
            res_rdata = rd_bytes;
        end else begin
            res_rdata = '0;
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (!st_busy) n_state = S_IDLE;
            S_IDLE: begin
                if (in_xfer && (i_in_data.op != mrd_pkg::OP_RSVD)) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if ((r_op != mrd_pkg::OP_ADD) && tbl_hit.mapped) begin
                    n_state = S_ADDR;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_ADDR:  n_state = S_BEAT0;
            S_BEAT0: n_state = S_BEAT1;
            S_BEAT1: n_state = S_FIN;
            S_FIN:   if (out_free) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Item registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op    <= i_in_data.op;
            r_addr  <= i_in_data.addr;
            r_size  <= i_in_data.size;
            r_hi    <= {1'b0, i_in_data.addr} + (mrd_pkg::ADDR_W + 1)'(i_in_data.size)
                       - (mrd_pkg::ADDR_W + 1)'(1);
            r_len   <= (i_in_data.len > mrd_pkg::LEN_W'(mrd_pkg::LANES)) ?
                       mrd_pkg::LEN_W'(mrd_pkg::LANES) : i_in_data.len;
            r_wdata <= i_in_data.wdata;
        end
        if (r_state == S_EVAL) begin
            if (r_op == mrd_pkg::OP_ADD) begin
                r_status <= tbl_add.status;
                r_region <= (tbl_add.status == mrd_pkg::ST_OK) ? tbl_add.region : '0;
                r_offset <= (tbl_add.status == mrd_pkg::ST_OK) ? tbl_add.offset : '0;
            end else begin
                r_idx    <= tbl_hit.idx;
                r_status <= tbl_hit.mapped ? mrd_pkg::ST_OK : mrd_pkg::ST_UNMAPPED;
                r_region <= '0;
                r_offset <= '0;
            end
        end
        if (r_state == S_ADDR) begin
            r_region <= mrd_pkg::REGION_W'(r_idx);
            r_offset <= off;
            r_start  <= start;
        end
        if (r_state == S_BEAT1) begin
            r_row0 <= st_rdata;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_FIN) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FIN) && out_free) begin
            r_out_data.status <= r_status;
            r_out_data.region <= r_region;
            r_out_data.offset <= r_offset;
            r_out_data.rdata  <= res_rdata;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // No item is taken while the store sweep runs
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !st_busy)
        else $error("input ready during store clearing");

    // Table is written only by a successful add
    a_commit_add_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_commit |-> (r_op == mrd_pkg::OP_ADD) && (r_state == S_EVAL))
        else $error("window table written outside an add");

    // Store lanes are written only by write items in their beats
    a_store_write_beats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (st_be != '0) |-> (r_op == mrd_pkg::OP_WRITE)
                          && ((r_state == S_BEAT0) || (r_state == S_BEAT1)))
        else $error("store written outside a write beat");

    // A finished result waits while the output register is occupied
    a_fin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) && r_out_valid && !i_out_ready |=> (r_state == S_FIN))
        else $error("result step left with the output register full");

endmodule
